[design/spe_pkg.sv]
// Shared constants, codes and the result record of the segment pattern expander.
// Used by every module of the block; has no dependencies of its own.
package spe_pkg;

  localparam int MAX_SEGMENTS = 256;
  localparam int LOGICAL_BITS = 8;
  localparam int SEG_AW       = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int GPIO_BITS    = 32;
  localparam int GPIO_SEL_W   = $clog2(GPIO_BITS);
  localparam int MAP_W        = LOGICAL_BITS * GPIO_SEL_W;
  localparam int DUR_W        = 32;
  localparam int PASS_W       = 32;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_ARM   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CFG_IDLE_MASK    = 2'd0,
    CFG_SEGS_IN_USE  = 2'd1,
    CFG_REPEAT_TOTAL = 2'd2,
    CFG_GPIO_MAP     = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [GPIO_BITS-1:0]    toggle_word;
    logic [LOGICAL_BITS-1:0] level_now;
    logic                    sample_valid;
    logic                    any_change;
    logic                    pattern_done;
    logic [SEG_AW-1:0]       segment_now;
  } sample_t;

endpackage

[design/segment_pattern_expander_unit.sv]
// Segment pattern expander: top level with configuration registers, the segment
// table, the sequencer and the result register. Uses spe_pkg, spe_seg_mem, spe_seq.
//
// One request enters every clock cycle while in_stall is low, and its result appears in
// the result register on the following edge, so an unstalled tick stream of an armed,
// unfinished pattern yields one sample per cycle. The rate rests on the sequencer's
// combinational pointer/count update and on the segment table being read ahead at the
// pointer the next tick will use. Table writes take effect for the very next tick. in_stall
// rises only while a result waits and out_stall is high. Configuration writes are always
// taken (cfg_ready is high) and belong to idle periods.
module segment_pattern_expander_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       kind,
  input  logic [7:0]                       entry_index,
  input  logic [7:0]                       entry_mask,
  input  logic [31:0]                      entry_duration,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [31:0]                      toggle_word,
  output logic [7:0]                       level_now,
  output logic                             sample_valid,
  output logic                             any_change,
  output logic                             pattern_done,
  output logic [7:0]                       segment_now,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [39:0]                      cfg_data
);

  logic [spe_pkg::LOGICAL_BITS-1:0] idle_mask;
  logic [8:0]                       segments_in_use;
  logic [spe_pkg::PASS_W-1:0]       repeat_total;
  logic [spe_pkg::MAP_W-1:0]        gpio_map;

  logic                             go;
  logic                             wr_en;
  logic [spe_pkg::SEG_AW-1:0]       wr_addr;
  logic [spe_pkg::SEG_AW-1:0]       rd_addr;
  logic [spe_pkg::LOGICAL_BITS-1:0] rd_mask;
  logic [spe_pkg::DUR_W-1:0]        rd_dur;
  spe_pkg::sample_t                 res;
  spe_pkg::sample_t                 res_q;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign go        = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_mask       <= '0;
      segments_in_use <= 9'd1;
      repeat_total    <= '0;
      gpio_map        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (spe_pkg::cfg_index_t'(cfg_index))
        spe_pkg::CFG_IDLE_MASK:    idle_mask       <= cfg_data[spe_pkg::LOGICAL_BITS-1:0];
        spe_pkg::CFG_SEGS_IN_USE:  segments_in_use <= cfg_data[8:0];
        spe_pkg::CFG_REPEAT_TOTAL: repeat_total    <= cfg_data[spe_pkg::PASS_W-1:0];
        spe_pkg::CFG_GPIO_MAP:     gpio_map        <= cfg_data[spe_pkg::MAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  spe_seg_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_mask (entry_mask),
    .wr_dur  (entry_duration),
    .rd_addr (rd_addr),
    .rd_mask (rd_mask),
    .rd_dur  (rd_dur)
  );

  spe_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .go              (go),
    .kind            (kind),
    .entry_index     (entry_index),
    .idle_mask       (idle_mask),
    .segments_in_use (segments_in_use),
    .repeat_total    (repeat_total),
    .gpio_map        (gpio_map),
    .rd_mask         (rd_mask),
    .rd_dur          (rd_dur),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .rd_addr         (rd_addr),
    .res             (res)
  );

  // Result register: load on an accepted request, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_q <= res;
    end
  end

  assign toggle_word  = res_q.toggle_word;
  assign level_now    = res_q.level_now;
  assign sample_valid = res_q.sample_valid;
  assign any_change   = res_q.any_change;
  assign pattern_done = res_q.pattern_done;
  assign segment_now  = res_q.segment_now;

endmodule

[design/spe_seg_mem.sv]
// Segment table: mask and duration per entry, one write port and one read port
// with registered read data and write-through on a same-address write. Uses spe_pkg.
module spe_seg_mem (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [spe_pkg::SEG_AW-1:0]       wr_addr,
  input  logic [spe_pkg::LOGICAL_BITS-1:0] wr_mask,
  input  logic [spe_pkg::DUR_W-1:0]        wr_dur,
  input  logic [spe_pkg::SEG_AW-1:0]       rd_addr,
  output logic [spe_pkg::LOGICAL_BITS-1:0] rd_mask,
  output logic [spe_pkg::DUR_W-1:0]        rd_dur
);

  logic [spe_pkg::LOGICAL_BITS-1:0] mask_mem [spe_pkg::MAX_SEGMENTS];
  logic [spe_pkg::DUR_W-1:0]        dur_mem  [spe_pkg::MAX_SEGMENTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mask_mem[wr_addr] <= wr_mask;
      dur_mem[wr_addr]  <= wr_dur;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_addr == rd_addr) begin
      rd_mask <= wr_mask;
      rd_dur  <= wr_dur;
    end else begin
      rd_mask <= mask_mem[rd_addr];
      rd_dur  <= dur_mem[rd_addr];
    end
  end

endmodule

[design/spe_remap.sv]
// Logical-to-physical toggle remap: each changed logical bit sets the GPIO bit
// that its 5-bit map field selects. Pure logic; uses spe_pkg.
module spe_remap (
  input  logic [spe_pkg::LOGICAL_BITS-1:0] delta,
  input  logic [spe_pkg::MAP_W-1:0]        gpio_map,
  output logic [spe_pkg::GPIO_BITS-1:0]    toggle
);

  always_comb begin
    toggle = '0;
    for (int b = 0; b < spe_pkg::LOGICAL_BITS; b++) begin
      if (delta[b]) begin
        toggle[gpio_map[b*spe_pkg::GPIO_SEL_W +: spe_pkg::GPIO_SEL_W]] = 1'b1;
      end
    end
  end

endmodule

[design/spe_seq.sv]
// Playback sequencer: level, segment pointer, sample count and pass count, updated
// once per accepted request. Drives the table ports; uses spe_pkg and spe_remap.
module spe_seq (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             go,
  input  logic [1:0]                       kind,
  input  logic [7:0]                       entry_index,
  input  logic [spe_pkg::LOGICAL_BITS-1:0] idle_mask,
  input  logic [8:0]                       segments_in_use,
  input  logic [spe_pkg::PASS_W-1:0]       repeat_total,
  input  logic [spe_pkg::MAP_W-1:0]        gpio_map,
  input  logic [spe_pkg::LOGICAL_BITS-1:0] rd_mask,
  input  logic [spe_pkg::DUR_W-1:0]        rd_dur,
  output logic                             wr_en,
  output logic [spe_pkg::SEG_AW-1:0]       wr_addr,
  output logic [spe_pkg::SEG_AW-1:0]       rd_addr,
  output spe_pkg::sample_t                 res
);

  logic [spe_pkg::LOGICAL_BITS-1:0] level, level_next;
  logic [spe_pkg::SEG_AW-1:0]       seg_pointer, seg_pointer_next;
  logic [spe_pkg::DUR_W-1:0]        samples_left, samples_left_next;
  logic [spe_pkg::PASS_W-1:0]       passes_done, passes_done_next;
  logic                             finished, finished_next;
  logic                             armed, armed_next;
  logic                             reload, reload_next;

  logic [spe_pkg::DUR_W-1:0]        left_now;
  logic [spe_pkg::CNT_W-1:0]        seg_count;
  logic [spe_pkg::CNT_W-1:0]        ptr_plus;
  logic [spe_pkg::PASS_W-1:0]       passes_inc;
  logic [spe_pkg::GPIO_BITS-1:0]    toggle;
  logic                             sample;

  spe_remap u_remap (
    .delta    (level ^ rd_mask),
    .gpio_map (gpio_map),
    .toggle   (toggle)
  );

  // Clamp the configured count to 1..MAX_SEGMENTS.
  always_comb begin
    if (segments_in_use == '0) begin
      seg_count = spe_pkg::CNT_W'(1);
    end else if (32'(segments_in_use) > spe_pkg::MAX_SEGMENTS) begin
      seg_count = spe_pkg::CNT_W'(spe_pkg::MAX_SEGMENTS);
    end else begin
      seg_count = spe_pkg::CNT_W'(segments_in_use);
    end
  end

  // The duration of a freshly entered segment arrives from the table's registered read
  // port once the pointer has moved; fold it in here.
  assign left_now   = reload ? rd_dur : samples_left;
  assign ptr_plus   = spe_pkg::CNT_W'(seg_pointer) + spe_pkg::CNT_W'(1);
  assign passes_inc = (passes_done != '1) ? passes_done + 1'b1 : passes_done;

  assign wr_en   = go && kind == spe_pkg::KIND_WRITE
                   && 32'(entry_index) < spe_pkg::MAX_SEGMENTS;
  assign wr_addr = entry_index[spe_pkg::SEG_AW-1:0];
  assign rd_addr = seg_pointer_next;

  always_comb begin
    level_next        = level;
    seg_pointer_next  = seg_pointer;
    samples_left_next = left_now;
    passes_done_next  = passes_done;
    finished_next     = finished;
    armed_next        = armed;
    reload_next       = 1'b0;
    sample            = 1'b0;
    if (go) begin
      unique case (kind)
        spe_pkg::KIND_TICK: begin
          if (armed && !finished) begin
            sample     = 1'b1;
            level_next = rd_mask;
            if (left_now > spe_pkg::DUR_W'(1)) begin
              samples_left_next = left_now - 1'b1;
            end else if (ptr_plus < seg_count) begin
              seg_pointer_next  = ptr_plus[spe_pkg::SEG_AW-1:0];
              samples_left_next = '0;
              reload_next       = 1'b1;
            end else begin
              passes_done_next  = passes_inc;
              samples_left_next = '0;
              if (repeat_total != '0 && passes_inc >= repeat_total) begin
                finished_next = 1'b1;
              end else begin
                seg_pointer_next = '0;
                reload_next      = 1'b1;
              end
            end
          end
        end
        spe_pkg::KIND_ARM: begin
          level_next        = idle_mask;
          seg_pointer_next  = '0;
          samples_left_next = '0;
          reload_next       = 1'b1;
          passes_done_next  = '0;
          finished_next     = 1'b0;
          armed_next        = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level        <= '0;
      seg_pointer  <= '0;
      samples_left <= '0;
      passes_done  <= '0;
      finished     <= 1'b0;
      armed        <= 1'b0;
      reload       <= 1'b0;
    end else begin
      level        <= level_next;
      seg_pointer  <= seg_pointer_next;
      samples_left <= samples_left_next;
      passes_done  <= passes_done_next;
      finished     <= finished_next;
      armed        <= armed_next;
      reload       <= reload_next;
    end
  end

  always_comb begin
    res.toggle_word  = sample ? toggle : '0;
    res.level_now    = level_next;
    res.sample_valid = sample;
    res.any_change   = sample && toggle != '0;
    res.pattern_done = finished_next;
    res.segment_now  = seg_pointer_next;
  end

endmodule
